@@ rtl/smeu_pkg.sv @@
// Shared constants and types for the stack machine execute unit.
`default_nettype none

package smeu_pkg;

    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 4;
    localparam int IDX_W    = 5;
    localparam int KIND_W   = 3;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int LOCAL_COUNT_DEF = 32;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [KIND_W-1:0]   kind_t;

    localparam opcode_t OP_CONST = 4'd0;
    localparam opcode_t OP_LOAD  = 4'd1;
    localparam opcode_t OP_STORE = 4'd2;
    localparam opcode_t OP_ADD   = 4'd3;
    localparam opcode_t OP_SUB   = 4'd4;
    localparam opcode_t OP_MUL   = 4'd5;
    localparam opcode_t OP_DIV   = 4'd6;
    localparam opcode_t OP_AND   = 4'd7;
    localparam opcode_t OP_OR    = 4'd8;
    localparam opcode_t OP_NOT   = 4'd9;
    localparam opcode_t OP_EQ    = 4'd10;
    localparam opcode_t OP_GT    = 4'd11;
    localparam opcode_t OP_LT    = 4'd12;
    localparam opcode_t OP_PRINT = 4'd13;
    localparam opcode_t OP_STOP  = 4'd14;

    localparam kind_t KIND_PRINT = 3'd0;
    localparam kind_t KIND_STOP  = 3'd1;
    localparam kind_t KIND_UNDER = 3'd2;
    localparam kind_t KIND_OVER  = 3'd3;
    localparam kind_t KIND_DIVZ  = 3'd4;

endpackage

`default_nettype wire

@@ rtl/stack_machine_execute_unit.sv @@
// Top level of the stack machine execute unit: sequencer, stores and shared adder.
`default_nettype none

// The unit executes one decoded stack-machine instruction per input beat and
// gives at most one result beat (a printed value, a stop notice or an error).
// It is not ready while an instruction is in flight, so instructions go one
// at a time. Const and an ignored instruction end in decode; load, store and
// not pass through a state of their own, stop through the emit state, print
// through its own state and the emit state, and the two-operand operations
// (add, sub, mul, and, or, eq, gt, lt) fetch the lower operand and compute;
// div then goes on to take its quotient from a restoring divider that
// retires one bit per cycle on the shared 34-bit adder. An error beat goes to
// the output stage from the emit state that follows its check. The same adder
// also does add, sub, the signed compares and the negations that the divider
// needs for signed operands; multiply is a single 32x32 product.
// Instructions with an out-of-range local index stay in decode while the index
// is reduced by LOCAL_COUNT until it is in range. The operand stack and the
// local variables live in single-port-write memories with registered reads.
// After reset the unit sweeps the local store to zero, one entry per cycle,
// and accepts no instruction until every entry has been cleared.
// Stack underflow, stack overflow and divide by zero give an error beat and
// leave the stack and locals untouched. After stop the unit ignores every
// further instruction until reset. A result beat waits in an output register;
// the unit only stalls if a second result is due before the first is taken.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
    parameter int LOCAL_COUNT = smeu_pkg::LOCAL_COUNT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [smeu_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic signed [smeu_pkg::WORD_W-1:0]  immediate,
    input  wire logic [smeu_pkg::IDX_W-1:0]          local_index,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [smeu_pkg::KIND_W-1:0]              kind,
    output logic signed [smeu_pkg::WORD_W-1:0]       value
);

    // Widths that follow from the parameters.
    localparam int DW   = $clog2(STACK_DEPTH + 1);
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int LAW  = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
    localparam int LCW  = $clog2(LOCAL_COUNT + 1);
    localparam int LXW  = (LCW > smeu_pkg::IDX_W) ? LCW : smeu_pkg::IDX_W;
    localparam int AW   = smeu_pkg::WORD_W + 2;

    // Sequencer state codes.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_STORE  = 4'd4;
    localparam logic [3:0] S_NOT    = 4'd5;
    localparam logic [3:0] S_PRINT  = 4'd6;
    localparam logic [3:0] S_RDA    = 4'd7;
    localparam logic [3:0] S_ALU    = 4'd8;
    localparam logic [3:0] S_DIVA   = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_DIVEND = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    localparam logic [4:0] DIV_LAST = 5'd31;

    // Control state.
    logic [3:0]              state_reg, state_next;
    logic [DW-1:0]           depth_reg, depth_next;
    logic                    halted_reg, halted_next;
    logic [LAW-1:0]          clr_reg, clr_next;
    logic [4:0]              step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload registers.
    smeu_pkg::opcode_t       op_reg, op_next;
    smeu_pkg::word_t         imm_reg, imm_next;
    logic [LXW-1:0]          li_reg, li_next;
    smeu_pkg::word_t         b_reg, b_next;
    smeu_pkg::word_t         a_reg, a_next;
    smeu_pkg::word_t         dvs_reg, dvs_next;
    smeu_pkg::word_t         quo_reg, quo_next;
    smeu_pkg::word_t         rem_reg, rem_next;
    logic                    negq_reg, negq_next;
    smeu_pkg::kind_t         pend_kind_reg, pend_kind_next;
    smeu_pkg::word_t         pend_value_reg, pend_value_next;
    smeu_pkg::kind_t         kind_reg, kind_next;
    smeu_pkg::word_t         value_reg, value_next;

    // Memories and their ports.
    smeu_pkg::word_t         stk_mem [STACK_DEPTH];
    smeu_pkg::word_t         loc_mem [LOCAL_COUNT];
    smeu_pkg::word_t         stk_q_reg;
    smeu_pkg::word_t         loc_q_reg;
    logic                    stk_we;
    logic [SAW-1:0]          stk_waddr;
    logic [SAW-1:0]          stk_raddr;
    smeu_pkg::word_t         stk_wdata;
    logic                    loc_we;
    logic [LAW-1:0]          loc_waddr;
    smeu_pkg::word_t         loc_wdata;

    // Shared adder and operation helpers.
    logic [AW-1:0]           alu_x;
    logic [AW-1:0]           alu_y;
    logic                    alu_sub;
    logic [AW-1:0]           alu_sum;
    logic [DW-1:0]           depth_m1;
    logic [DW-1:0]           depth_m2;
    logic                    stk_full;
    logic                    li_ok;
    logic [LAW-1:0]          li_addr;
    smeu_pkg::word_t         mul_lo;
    smeu_pkg::word_t         alu_result;
    logic [2*smeu_pkg::WORD_W-1:0] mul_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign stk_full = (depth_reg == DW'(STACK_DEPTH));
    assign li_ok    = (li_reg < LXW'(LOCAL_COUNT));
    assign li_addr  = li_reg[LAW-1:0];

    // In S_ALU the lower operand arrives straight from the stack read register.
    assign mul_full = stk_q_reg * b_reg;
    assign mul_lo   = mul_full[smeu_pkg::WORD_W-1:0];

    assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + AW'(alu_sub);

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            S_ALU:
            begin
                unique case (op_reg)
                    smeu_pkg::OP_ADD:
                    begin
                        alu_x   = {{2{stk_q_reg[31]}}, stk_q_reg};
                        alu_y   = {{2{b_reg[31]}}, b_reg};
                        alu_sub = 1'b0;
                    end
                    smeu_pkg::OP_GT:
                    begin
                        // b - a is negative exactly when a > b.
                        alu_x = {{2{b_reg[31]}}, b_reg};
                        alu_y = {{2{stk_q_reg[31]}}, stk_q_reg};
                    end
                    smeu_pkg::OP_DIV:
                    begin
                        // Negate the divisor; the abs value is picked below.
                        alu_y = {2'b00, b_reg};
                    end
                    default:
                    begin
                        alu_x = {{2{stk_q_reg[31]}}, stk_q_reg};
                        alu_y = {{2{b_reg[31]}}, b_reg};
                    end
                endcase
            end
            S_DIVA:   alu_y = {2'b00, a_reg};
            S_DIV:
            begin
                alu_x = {1'b0, rem_reg, quo_reg[31]};
                alu_y = {2'b00, dvs_reg};
            end
            S_DIVEND: alu_y = {2'b00, quo_reg};
            default:
            begin
                alu_x = '0;
                alu_y = '0;
            end
        endcase
    end

    // Result of the simple two-operand operations.
    always_comb
    begin
        unique case (op_reg)
            smeu_pkg::OP_ADD,
            smeu_pkg::OP_SUB: alu_result = alu_sum[smeu_pkg::WORD_W-1:0];
            smeu_pkg::OP_MUL: alu_result = mul_lo;
            smeu_pkg::OP_AND:
                alu_result = smeu_pkg::word_t'((stk_q_reg != '0) && (b_reg != '0));
            smeu_pkg::OP_OR:
                alu_result = smeu_pkg::word_t'((stk_q_reg != '0) || (b_reg != '0));
            smeu_pkg::OP_EQ:  alu_result = smeu_pkg::word_t'(stk_q_reg == b_reg);
            smeu_pkg::OP_GT,
            smeu_pkg::OP_LT:  alu_result = smeu_pkg::word_t'(alu_sum[AW-1]);
            default:          alu_result = '0;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        halted_next     = halted_reg;
        clr_next        = clr_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        imm_next        = imm_reg;
        li_next         = li_reg;
        b_next          = b_reg;
        a_next          = a_reg;
        dvs_next        = dvs_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        negq_next       = negq_reg;
        pend_kind_next  = pend_kind_reg;
        pend_value_next = pend_value_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        stk_we    = 1'b0;
        stk_waddr = depth_reg[SAW-1:0];
        stk_wdata = imm_reg;
        stk_raddr = depth_m1[SAW-1:0];
        loc_we    = 1'b0;
        loc_waddr = li_addr;
        loc_wdata = stk_q_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                loc_we    = 1'b1;
                loc_waddr = clr_reg;
                loc_wdata = '0;
                clr_next  = clr_reg + LAW'(1);
                if (clr_reg == LAW'(LOCAL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    imm_next   = immediate;
                    li_next    = LXW'(local_index);
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                pend_value_next = '0;
                priority if (halted_reg || (op_reg > smeu_pkg::OP_STOP))
                begin
                    state_next = S_IDLE;
                end
                else if (!li_ok)
                begin
                    // Reduce the local index modulo LOCAL_COUNT.
                    li_next = li_reg - LXW'(LOCAL_COUNT);
                end
                else
                begin
                    unique case (op_reg)
                        smeu_pkg::OP_CONST,
                        smeu_pkg::OP_LOAD:
                        begin
                            if (stk_full)
                            begin
                                pend_kind_next = smeu_pkg::KIND_OVER;
                                state_next     = S_EMIT;
                            end
                            else if (op_reg == smeu_pkg::OP_CONST)
                            begin
                                stk_we     = 1'b1;
                                depth_next = depth_reg + DW'(1);
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        smeu_pkg::OP_STOP:
                        begin
                            halted_next    = 1'b1;
                            pend_kind_next = smeu_pkg::KIND_STOP;
                            state_next     = S_EMIT;
                        end
                        smeu_pkg::OP_STORE,
                        smeu_pkg::OP_NOT,
                        smeu_pkg::OP_PRINT:
                        begin
                            if (depth_reg == '0)
                            begin
                                pend_kind_next = smeu_pkg::KIND_UNDER;
                                state_next     = S_EMIT;
                            end
                            else if (op_reg == smeu_pkg::OP_STORE)
                            begin
                                state_next = S_STORE;
                            end
                            else if (op_reg == smeu_pkg::OP_NOT)
                            begin
                                state_next = S_NOT;
                            end
                            else
                            begin
                                state_next = S_PRINT;
                            end
                        end
                        default:
                        begin
                            if (depth_reg < DW'(2))
                            begin
                                pend_kind_next = smeu_pkg::KIND_UNDER;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RDA;
                            end
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                stk_we     = 1'b1;
                stk_wdata  = loc_q_reg;
                depth_next = depth_reg + DW'(1);
                state_next = S_IDLE;
            end

            S_STORE:
            begin
                loc_we     = 1'b1;
                depth_next = depth_m1;
                state_next = S_IDLE;
            end

            S_NOT:
            begin
                stk_we     = 1'b1;
                stk_waddr  = depth_m1[SAW-1:0];
                stk_wdata  = smeu_pkg::word_t'(stk_q_reg == '0);
                state_next = S_IDLE;
            end

            S_PRINT:
            begin
                depth_next      = depth_m1;
                pend_kind_next  = smeu_pkg::KIND_PRINT;
                pend_value_next = stk_q_reg;
                state_next      = S_EMIT;
            end

            S_RDA:
            begin
                // The top word is in the read register; fetch the one below it.
                b_next     = stk_q_reg;
                stk_raddr  = depth_m2[SAW-1:0];
                state_next = S_ALU;
            end

            S_ALU:
            begin
                if (op_reg == smeu_pkg::OP_DIV)
                begin
                    if (b_reg == '0)
                    begin
                        pend_kind_next = smeu_pkg::KIND_DIVZ;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        a_next     = stk_q_reg;
                        dvs_next   = b_reg[31] ? alu_sum[smeu_pkg::WORD_W-1:0] : b_reg;
                        negq_next  = stk_q_reg[31] ^ b_reg[31];
                        state_next = S_DIVA;
                    end
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = depth_m2[SAW-1:0];
                    stk_wdata  = alu_result;
                    depth_next = depth_m1;
                    state_next = S_IDLE;
                end
            end

            S_DIVA:
            begin
                quo_next   = a_reg[31] ? alu_sum[smeu_pkg::WORD_W-1:0] : a_reg;
                rem_next   = '0;
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // One restoring step: keep the trial difference when it is not negative.
                if (alu_sum[AW-1])
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                end
                else
                begin
                    rem_next = alu_sum[smeu_pkg::WORD_W-1:0];
                end
                quo_next  = {quo_reg[30:0], !alu_sum[AW-1]};
                step_next = step_reg + 5'd1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_DIVEND;
                end
            end

            S_DIVEND:
            begin
                stk_we     = 1'b1;
                stk_waddr  = depth_m2[SAW-1:0];
                stk_wdata  = negq_reg ? alu_sum[smeu_pkg::WORD_W-1:0] : quo_reg;
                depth_next = depth_m1;
                state_next = S_IDLE;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = pend_kind_reg;
                    value_next     = pend_value_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            depth_reg     <= '0;
            halted_reg    <= 1'b0;
            clr_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            halted_reg    <= halted_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        imm_reg        <= imm_next;
        li_reg         <= li_next;
        b_reg          <= b_next;
        a_reg          <= a_next;
        dvs_reg        <= dvs_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        negq_reg       <= negq_next;
        pend_kind_reg  <= pend_kind_next;
        pend_value_reg <= pend_value_next;
        kind_reg       <= kind_next;
        value_reg      <= value_next;
    end

    // Operand stack memory.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q_reg <= stk_mem[stk_raddr];
    end

    // Local variable memory.
    always_ff @(posedge clk)
    begin
        if (loc_we)
        begin
            loc_mem[loc_waddr] <= loc_wdata;
        end
        loc_q_reg <= loc_mem[li_addr];
    end

    // The stack pointer never runs past the stack.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // Once stopped, the unit stays stopped.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared");

    // A stop result is only ever shown after the unit has halted.
    a_stop_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == smeu_pkg::KIND_STOP)) |-> halted_reg)
        else $error("stop result without halt");

    // Only a printed value carries a nonzero value field.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != smeu_pkg::KIND_PRINT)) |-> (value == '0))
        else $error("nonzero value on non-print result");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the stack machine execute unit: predicted result beats vs. DUT.
`default_nettype none

module tb_top;

    localparam int STACK_N      = smeu_pkg::STACK_DEPTH_DEF;
    localparam int LOCALS_N     = smeu_pkg::LOCAL_COUNT_DEF;
    localparam int WORD_BITS    = smeu_pkg::WORD_W;
    localparam int IDX_BITS     = smeu_pkg::IDX_W;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 400;

    localparam smeu_pkg::opcode_t OP_UNUSED = 4'd15;
    localparam smeu_pkg::word_t   WORD_MIN  = 32'h8000_0000;
    localparam smeu_pkg::word_t   WORD_MAX  = 32'h7FFF_FFFF;
    localparam smeu_pkg::word_t   WORD_ONES = 32'hFFFF_FFFF;

    typedef enum int {MODE_MIXED, MODE_FILL, MODE_DRAIN} stim_mode_t;

    typedef struct packed {
        smeu_pkg::kind_t kind;
        smeu_pkg::word_t value;
    } result_beat_t;

    // Keeps its own copy of the machine state and the result beats that are still owed.
    class exec_scoreboard_t;
        smeu_pkg::word_t stack_mem [STACK_N];
        smeu_pkg::word_t locals [LOCALS_N];
        int unsigned     depth;
        bit              halted;
        result_beat_t    expected_beats [$];
        int              failures;

        function new();
            foreach (stack_mem[i]) stack_mem[i] = '0;
            foreach (locals[i]) locals[i] = '0;
            depth    = 0;
            halted   = 1'b0;
            failures = 0;
        endfunction

        function void queue_result(smeu_pkg::kind_t k, smeu_pkg::word_t v);
            result_beat_t beat;
            beat.kind  = k;
            beat.value = v;
            expected_beats.insert(expected_beats.size(), beat);
        endfunction

        // Executes one accepted instruction on the shadow state.
        function void note_instruction(smeu_pkg::opcode_t op, smeu_pkg::word_t imm,
                                       logic [IDX_BITS-1:0] idx);
            smeu_pkg::word_t a;
            smeu_pkg::word_t b;
            smeu_pkg::word_t r;
            longint          sa;
            longint          sb;
            int unsigned     li;
            li = idx % LOCALS_N;
            if (halted || op > smeu_pkg::OP_STOP)
                return;
            case (op)
                smeu_pkg::OP_CONST, smeu_pkg::OP_LOAD:
                begin
                    if (depth >= STACK_N)
                        queue_result(smeu_pkg::KIND_OVER, '0);
                    else
                    begin
                        stack_mem[depth] = (op == smeu_pkg::OP_CONST) ? imm : locals[li];
                        depth++;
                    end
                end
                smeu_pkg::OP_STORE:
                begin
                    if (depth < 1)
                        queue_result(smeu_pkg::KIND_UNDER, '0);
                    else
                    begin
                        depth--;
                        locals[li] = stack_mem[depth];
                    end
                end
                smeu_pkg::OP_NOT:
                begin
                    if (depth < 1)
                        queue_result(smeu_pkg::KIND_UNDER, '0);
                    else
                        stack_mem[depth-1] = smeu_pkg::word_t'(stack_mem[depth-1] == '0);
                end
                smeu_pkg::OP_PRINT:
                begin
                    if (depth < 1)
                        queue_result(smeu_pkg::KIND_UNDER, '0);
                    else
                    begin
                        depth--;
                        queue_result(smeu_pkg::KIND_PRINT, stack_mem[depth]);
                    end
                end
                smeu_pkg::OP_STOP:
                begin
                    halted = 1'b1;
                    queue_result(smeu_pkg::KIND_STOP, '0);
                end
                default:
                begin
                    // Two-operand operations; a sits below b on the stack.
                    if (depth < 2)
                        queue_result(smeu_pkg::KIND_UNDER, '0);
                    else
                    begin
                        b  = stack_mem[depth-1];
                        a  = stack_mem[depth-2];
                        sa = longint'($signed(a));
                        sb = longint'($signed(b));
                        if (op == smeu_pkg::OP_DIV && b == '0)
                            queue_result(smeu_pkg::KIND_DIVZ, '0);
                        else
                        begin
                            case (op)
                                smeu_pkg::OP_ADD: r = a + b;
                                smeu_pkg::OP_SUB: r = a - b;
                                smeu_pkg::OP_MUL: r = a * b;
                                smeu_pkg::OP_DIV: r = smeu_pkg::word_t'(sa / sb);
                                smeu_pkg::OP_AND:
                                    r = smeu_pkg::word_t'((a != '0) && (b != '0));
                                smeu_pkg::OP_OR:
                                    r = smeu_pkg::word_t'((a != '0) || (b != '0));
                                smeu_pkg::OP_EQ:  r = smeu_pkg::word_t'(a == b);
                                smeu_pkg::OP_GT:  r = smeu_pkg::word_t'(sa > sb);
                                default:          r = smeu_pkg::word_t'(sa < sb);
                            endcase
                            depth--;
                            stack_mem[depth-1] = r;
                        end
                    end
                end
            endcase
        endfunction

        function void check_beat(smeu_pkg::kind_t k, smeu_pkg::word_t v);
            result_beat_t want;
            if (expected_beats.size() == 0)
            begin
                failures++;
                $display("%0t: result beat with none expected: kind %0d value %h", $time, k, v);
                return;
            end
            want = expected_beats.pop_front();
            if (k !== want.kind)
            begin
                failures++;
                $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, k);
            end
            if (v !== want.value)
            begin
                failures++;
                $display("%0t: value mismatch: expected %h, actual %h", $time, want.value, v);
            end
        endfunction
    endclass

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    smeu_pkg::opcode_t           opcode      = smeu_pkg::OP_CONST;
    logic signed [WORD_BITS-1:0] immediate   = '0;
    logic [IDX_BITS-1:0]         local_index = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    smeu_pkg::kind_t             kind;
    logic signed [WORD_BITS-1:0] value;

    exec_scoreboard_t board;
    int               items_sent  = 0;
    int               burst_left  = 0;
    int               cycle_count = 0;
    bit               hold_done   = 1'b0;

    stack_machine_execute_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .immediate   (immediate),
        .local_index (local_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** stack_machine_execute_unit: FAILED **");
            $finish;
        end
    end

    // Every result beat taken by the receiver is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_beat(kind, value);
    end

    // Receiver: segments of always-ready, coin-flip and periodic acceptance, plus one long
    // hold-off so that the output register fills and the unit stops taking instructions.
    initial
    begin : receiver
        int seg_len;
        int style;
        int period;
        forever
        begin
            seg_len = $urandom_range(20, 200);
            style   = $urandom_range(0, 2);
            period  = $urandom_range(2, 6);
            for (int c = 0; c < seg_len; c++)
            begin
                @(posedge clk);
                if (!hold_done && items_sent >= HOLD_AFTER)
                begin
                    hold_done = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (c % period == 0);
                endcase
            end
        end
    end

    function automatic smeu_pkg::word_t rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return WORD_ONES;
            3:       return WORD_MIN;
            4:       return WORD_MAX;
            5, 6:    return smeu_pkg::word_t'(int'($urandom_range(0, 20)) - 10);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [IDX_BITS-1:0] rand_idx();
        return IDX_BITS'($urandom_range(0, LOCALS_N - 1));
    endfunction

    function automatic smeu_pkg::opcode_t rand_binop();
        case ($urandom_range(0, 8))
            0:       return smeu_pkg::OP_ADD;
            1:       return smeu_pkg::OP_SUB;
            2:       return smeu_pkg::OP_MUL;
            3, 4:    return smeu_pkg::OP_DIV;
            5:       return smeu_pkg::OP_AND;
            6:       return smeu_pkg::OP_OR;
            7:       return smeu_pkg::OP_EQ;
            default: return ($urandom_range(0, 1) != 0) ? smeu_pkg::OP_GT : smeu_pkg::OP_LT;
        endcase
    endfunction

    // Offers one instruction beat and waits for the handshake. Beats go out in bursts;
    // the gap before a burst is the only place the valid line drops.
    task automatic send_instr(smeu_pkg::opcode_t op, smeu_pkg::word_t imm,
                              logic [IDX_BITS-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        opcode      <= op;
        immediate   <= imm;
        local_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_instruction(op, imm, idx);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Any opcode but stop, the unused one included, with random operands.
    task automatic send_random_op();
        smeu_pkg::opcode_t op;
        op = smeu_pkg::opcode_t'($urandom_range(0, 15));
        if (op == smeu_pkg::OP_STOP)
            op = smeu_pkg::OP_PRINT;
        send_instr(op, rand_word(), rand_idx());
    endtask

    // Short well-formed programs that end in a print.
    task automatic send_program();
        logic [IDX_BITS-1:0] idx;
        idx = rand_idx();
        case ($urandom_range(0, 3))
            0:
            begin
                send_instr(smeu_pkg::OP_CONST, rand_word(), rand_idx());
                send_instr(smeu_pkg::OP_CONST, rand_word(), rand_idx());
                send_instr(rand_binop(), rand_word(), rand_idx());
            end
            1:
            begin
                send_instr(smeu_pkg::OP_CONST, rand_word(), rand_idx());
                send_instr(smeu_pkg::OP_NOT, rand_word(), rand_idx());
            end
            2:
            begin
                send_instr(smeu_pkg::OP_CONST, rand_word(), rand_idx());
                send_instr(smeu_pkg::OP_STORE, rand_word(), idx);
                send_instr(smeu_pkg::OP_LOAD, rand_word(), idx);
            end
            default:
            begin
                send_instr(smeu_pkg::OP_CONST, rand_word(), rand_idx());
                send_instr(smeu_pkg::OP_LOAD, rand_word(), rand_idx());
                send_instr(smeu_pkg::OP_CONST, rand_word(), rand_idx());
                send_instr(rand_binop(), rand_word(), rand_idx());
                send_instr(rand_binop(), rand_word(), rand_idx());
            end
        endcase
        send_instr(smeu_pkg::OP_PRINT, rand_word(), rand_idx());
    endtask

    initial
    begin : stimulus
        stim_mode_t mode;
        int         mode_left;
        int         target;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: underflow on an empty stack, wrap-around add, most negative over
        // minus one, divide by zero, store and load at the top index, and an unused opcode.
        send_instr(smeu_pkg::OP_PRINT, '0, '0);
        send_instr(smeu_pkg::OP_ADD, WORD_ONES, '1);
        send_instr(smeu_pkg::OP_CONST, WORD_MAX, '0);
        send_instr(smeu_pkg::OP_CONST, 32'd1, '0);
        send_instr(smeu_pkg::OP_ADD, '0, '0);
        send_instr(smeu_pkg::OP_CONST, WORD_ONES, '0);
        send_instr(smeu_pkg::OP_DIV, '0, '0);
        send_instr(smeu_pkg::OP_STORE, '0, '1);
        send_instr(smeu_pkg::OP_LOAD, '0, '1);
        send_instr(smeu_pkg::OP_PRINT, '0, '0);
        send_instr(smeu_pkg::OP_LOAD, '0, '1);
        send_instr(smeu_pkg::OP_CONST, '0, '0);
        send_instr(smeu_pkg::OP_DIV, '0, '0);
        send_instr(smeu_pkg::OP_MUL, '0, '0);
        send_instr(smeu_pkg::OP_NOT, '0, '0);
        send_instr(smeu_pkg::OP_CONST, WORD_MIN, '0);
        send_instr(smeu_pkg::OP_LT, '0, '0);
        send_instr(smeu_pkg::OP_LOAD, '0, '0);
        send_instr(smeu_pkg::OP_OR, '0, '0);
        send_instr(smeu_pkg::OP_CONST, 32'd3, '0);
        send_instr(smeu_pkg::OP_GT, '0, '0);
        send_instr(smeu_pkg::OP_CONST, '0, '0);
        send_instr(smeu_pkg::OP_AND, '0, '0);
        send_instr(OP_UNUSED, WORD_ONES, '1);
        send_instr(smeu_pkg::OP_CONST, WORD_MIN, '0);
        send_instr(smeu_pkg::OP_EQ, '0, '0);
        send_instr(smeu_pkg::OP_CONST, 32'd9, '0);
        send_instr(smeu_pkg::OP_SUB, '0, '0);
        send_instr(smeu_pkg::OP_PRINT, '0, '0);

        // Random part. The first mode is a long fill, which drives the stack into overflow.
        target    = items_sent + RANDOM_ITEMS;
        mode      = MODE_FILL;
        mode_left = 120;
        while (items_sent < target)
        begin
            if (mode_left == 0)
            begin
                mode      = stim_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                MODE_FILL:
                begin
                    if ($urandom_range(0, 99) < 90)
                        send_instr(($urandom_range(0, 1) != 0) ? smeu_pkg::OP_CONST
                                                               : smeu_pkg::OP_LOAD,
                                   rand_word(), rand_idx());
                    else
                        send_random_op();
                end
                MODE_DRAIN:
                begin
                    if ($urandom_range(0, 99) < 70)
                    begin
                        case ($urandom_range(0, 3))
                            0:       send_instr(smeu_pkg::OP_PRINT, rand_word(), rand_idx());
                            1:       send_instr(smeu_pkg::OP_STORE, rand_word(), rand_idx());
                            2:       send_instr(smeu_pkg::OP_NOT, rand_word(), rand_idx());
                            default: send_instr(rand_binop(), rand_word(), rand_idx());
                        endcase
                    end
                    else
                        send_random_op();
                end
                default:
                begin
                    if ($urandom_range(0, 9) < 6)
                        send_program();
                    else
                        send_random_op();
                end
            endcase
        end

        // Stop halts the unit; everything after it, a second stop included, is dropped.
        send_instr(smeu_pkg::OP_STOP, rand_word(), rand_idx());
        send_instr(smeu_pkg::OP_CONST, WORD_ONES, '1);
        send_instr(smeu_pkg::OP_PRINT, '0, '0);
        send_instr(smeu_pkg::OP_STOP, '0, '0);
        send_instr(OP_UNUSED, WORD_ONES, '1);
        in_valid <= 1'b0;

        while (board.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.expected_beats.size() == 0)
            $display("** stack_machine_execute_unit: PASSED **");
        else
            $display("** stack_machine_execute_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
